// ===== sv/rcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants of the RGB 3x3 convolution filter.
// ----------------------------------------------------------------------------
package rcf_pkg;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MAC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic [2:0] REG_KERNEL_UPPER = 3'd0;
  localparam logic [2:0] REG_KERNEL_LOWER = 3'd1;
  localparam logic [2:0] REG_DIVISOR      = 3'd2;
  localparam logic [2:0] REG_WIDTH        = 3'd3;
  localparam logic [2:0] REG_HEIGHT       = 3'd4;

  localparam int ACC_W   = 22;  // signed channel sum
  localparam int QUO_W   = 21;  // magnitude of a positive sum
  localparam int DIV_W   = 10;
  localparam int CLAMP_MAX = 255;

endpackage
`default_nettype wire

// ===== sv/rgb_conv3x3_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter
// 3x3 RGB convolution with signed coefficients, divisor and 0..255 clamp.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the slave stream, one beat per pixel; one
// filtered pixel leaves on the master stream for every interior pixel. A
// pixel at a border passes a read of the shared line memory, then write-back
// and window shift; one that yields a result passes the same read and
// write-back, then a multiply-accumulate over the nine taps through one
// multiplier per channel, a load of the divider, the bit-serial divider,
// and a load of the output register; that last step waits while an
// earlier result still sits unaccepted on the master stream. The
// line memory holds both previous rows in one entry per column and needs no
// clearing after reset. Registers sit on APB at 8*index.
module rgb_conv3x3_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // red_out, green_out, blue_out
  output logic             m_tlast,   // frame_last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import rcf_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [59:0] kernel_upper;
  logic [29:0] kernel_lower;
  logic [9:0]  divisor;
  logic [10:0] image_width;
  logic [11:0] image_height;

  state_t      state;
  logic [CW-1:0] column_count;
  logic [11:0] row_count;
  logic [23:0] pix;
  logic        has_result;
  logic        last_flag;
  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] line_rd;
  logic [23:0] win [3][3];  // [column oldest..newest][row top..bottom]
  logic [3:0]  step;
  logic [1:0]  mi, mj;
  logic signed [ACC_W-1:0] acc [3];
  logic [QUO_W-1:0] quo [3];
  logic [DIV_W-1:0] rem [3];
  logic [4:0]  div_cnt;

  logic        cfg_wr, in_acc, cnt_clr;
  logic [31:0] w_eff, h_eff;
  logic        last_col, last_row;
  logic signed [9:0] coef [9];
  logic [9:0]  dv_eff;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cnt_clr  = cfg_wr && (paddr[5:3] == REG_WIDTH || paddr[5:3] == REG_HEIGHT);
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign dv_eff   = (divisor == 10'd0) ? 10'd1 : divisor;

  always_comb begin
    case (paddr[5:3])
      REG_KERNEL_UPPER: prdata = {4'd0, kernel_upper};
      REG_KERNEL_LOWER: prdata = {34'd0, kernel_lower};
      REG_DIVISOR:      prdata = {54'd0, divisor};
      REG_WIDTH:        prdata = {53'd0, image_width};
      REG_HEIGHT:       prdata = {52'd0, image_height};
      default:          prdata = 64'd0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 6; k++) coef[k] = kernel_upper[10*k +: 10];
    for (int k = 0; k < 3; k++) coef[k+6] = kernel_lower[10*k +: 10];
  end

  always_comb begin
    if (image_width < 11'd3) w_eff = 32'd3;
    else if (32'(image_width) > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    else w_eff = 32'(image_width);
    h_eff    = (image_height < 12'd3) ? 32'd3 : 32'(image_height);
    last_col = (32'(column_count) + 32'd1) >= w_eff;
    last_row = (32'(row_count) + 32'd1) >= h_eff;
  end

  // line memory: one entry per column holds {row above, row two above}
  always_ff @(posedge clk) begin
    if (in_acc) line_rd <= line_mem[column_count];
    if (state == S_READ) line_mem[column_count] <= {pix, line_rd[47:24]};
  end

  // one multiply-accumulate per channel per step
  logic [23:0] tap;
  logic signed [ACC_W-1:0] prod [3];
  always_comb begin
    tap = win[mj][mi];
    for (int c = 0; c < 3; c++)
      prod[c] = $signed(ACC_W'({1'b0, tap[8*c +: 8]})) * ACC_W'(coef[step]);
  end

  logic [DIV_W:0] rsh [3];
  logic           qb [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rsh[c] = {rem[c], quo[c][QUO_W-1]};
      qb[c]  = rsh[c] >= {1'b0, dv_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_upper <= '0;
      kernel_lower <= '0;
      divisor      <= 10'd1;
      image_width  <= 11'd3;
      image_height <= 12'd3;
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      m_tvalid     <= 1'b0;
      for (int j = 0; j < 3; j++)
        for (int i = 0; i < 3; i++) win[j][i] <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      if (cfg_wr) begin
        case (paddr[5:3])
          REG_KERNEL_UPPER: kernel_upper <= pwdata[59:0];
          REG_KERNEL_LOWER: kernel_lower <= pwdata[29:0];
          REG_DIVISOR:      divisor <= pwdata[9:0];
          REG_WIDTH:        image_width  <= pwdata[10:0];
          REG_HEIGHT:       image_height <= pwdata[11:0];
          default: ;
        endcase
      end
      // a size write restarts the frame; otherwise advance the raster position
      if (cnt_clr) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (state == S_READ) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? 12'd0 : row_count + 12'd1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pix        <= s_tdata;
            has_result <= (row_count >= 12'd2) && (32'(column_count) >= 32'd2);
            last_flag  <= last_col && last_row;
            state      <= S_READ;
          end
        end
        S_READ: begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2][0] <= line_rd[23:0];
          win[2][1] <= line_rd[47:24];
          win[2][2] <= pix;
          step <= '0;
          mi   <= '0;
          mj   <= '0;
          for (int c = 0; c < 3; c++) acc[c] <= '0;
          state <= has_result ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          for (int c = 0; c < 3; c++) acc[c] <= acc[c] + prod[c];
          step <= step + 4'd1;
          if (mj == 2'd2) begin
            mj <= '0;
            mi <= mi + 2'd1;
          end else begin
            mj <= mj + 2'd1;
          end
          if (step == 4'd8) begin
            state   <= S_DIV;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          if (div_cnt == 5'd0 && step == 4'd9) begin
            // load dividends; a negative sum clamps to zero
            for (int c = 0; c < 3; c++) begin
              quo[c] <= acc[c][ACC_W-1] ? '0 : acc[c][QUO_W-1:0];
              rem[c] <= '0;
            end
            step <= '0;
          end else begin
            for (int c = 0; c < 3; c++) begin
              quo[c] <= {quo[c][QUO_W-2:0], qb[c]};
              rem[c] <= qb[c] ? DIV_W'(rsh[c] - {1'b0, dv_eff}) : rsh[c][DIV_W-1:0];
            end
            div_cnt <= div_cnt + 5'd1;
            if (div_cnt == 5'(QUO_W - 1)) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            for (int c = 0; c < 3; c++)
              m_tdata[8*c +: 8] <= (quo[c] > QUO_W'(CLAMP_MAX)) ? 8'hFF : quo[c][7:0];
            m_tlast  <= last_flag;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_acc_read: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_READ)
    else $error("accepted beat did not start a memory read");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result loaded outside output state");
  a_mac_step: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> step <= 4'd8)
    else $error("multiply-accumulate ran past nine taps");

endmodule
`default_nettype wire
